@@ sv/sse_pkg.sv @@
// Shared types and constants of the sorted set engine.
package sse_pkg;

  // Width of one held element.
  localparam int unsigned ElemW = 32;

  // Operation codes carried on the input tuser.
  typedef enum logic [1:0] {
    SSE_MODE_QUERY  = 2'd0,
    SSE_MODE_INSERT = 2'd1,
    SSE_MODE_DELETE = 2'd2,
    SSE_MODE_SPARE  = 2'd3
  } sse_mode_e;

  // Result status codes carried on the output tuser.
  typedef enum logic [1:0] {
    SSE_ST_DONE      = 2'd0,
    SSE_ST_DUP       = 2'd1,
    SSE_ST_NOT_FOUND = 2'd2,
    SSE_ST_FULL      = 2'd3
  } sse_status_e;

  // Command broadcast to every cell of the row.
  typedef enum logic [1:0] {
    SSE_CMD_HOLD   = 2'd0,
    SSE_CMD_INSERT = 2'd1,
    SSE_CMD_DELETE = 2'd2
  } sse_cmd_e;

  // Broadcast control: command and the value under test.
  typedef struct packed {
    sse_cmd_e                 cmd;
    logic signed [ElemW-1:0]  value;
  } sse_ctrl_t;

  // What a cell shows to its neighbours and to the top level.
  typedef struct packed {
    logic                     valid;  // cell holds an element
    logic                     gt;     // held element is above the value
    logic                     ge;     // held element is not below the value
    logic                     eq;     // held element equals the value
    logic signed [ElemW-1:0]  elem;
  } sse_link_t;

endpackage

@@ sv/sorted_set_engine.sv @@
// Top level of the sorted set engine: cell row, result logic and stream ports.
//
// Holds up to CAPACITY distinct signed 32-bit values in ascending order in a row
// of cells. Each input transaction (tuser = operation, tdata = value) is a
// membership query, an insert or a delete, and yields exactly one output
// transaction with the status, whether the value was held beforehand and the
// element count afterwards. One transaction is taken per clock cycle while the
// downstream side takes results: every cell compares the broadcast value at once
// and shifts towards its neighbour in the same cycle; the result is registered.
// The output register frees itself in the cycle it is taken, so the input stalls
// only while a result is held back by the downstream side. Nothing is held after
// reset: the set starts empty and no clearing pass is needed.
module sorted_set_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] was_present, [5:1] count, [7:6] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned CountW = $clog2(CAPACITY + 1);

  sse_pkg::sse_ctrl_t         ctrl;
  sse_pkg::sse_link_t         links   [CAPACITY];
  sse_pkg::sse_link_t         left_in [CAPACITY];
  sse_pkg::sse_link_t         right_in[CAPACITY];
  logic [CAPACITY-1:0]        eq_vec;
  logic                       present;
  logic                       full;
  logic                       accept;
  sse_pkg::sse_mode_e         mode;
  sse_pkg::sse_status_e       status;
  logic [CountW-1:0]          count_q, count_d;
  logic                       out_valid_q;
  sse_pkg::sse_status_e       out_status_q;
  logic                       out_present_q;
  logic [4:0]                 out_count_q;

  // Handshake: a new transaction enters whenever the result register can move.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mode          = sse_pkg::sse_mode_e'(s_axis_tuser);
  assign full          = (count_q == CountW'(CAPACITY));

  // Neighbour wiring, with fixed boundaries at both ends of the row.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      always_comb begin
        left_in[i]       = '0;
        left_in[i].valid = 1'b1;
      end
    end else begin : g_mid_left
      assign left_in[i] = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in[i] = '0;
    end else begin : g_mid_right
      assign right_in[i] = links[i+1];
    end
    assign eq_vec[i] = links[i].eq;

    sse_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left_in[i]),
      .right_i (right_in[i]),
      .link_o  (links[i])
    );
  end

  assign present = |eq_vec;

  // Decide the command for the row, the status and the new count.
  always_comb begin
    ctrl.value = $signed(s_axis_tdata);
    ctrl.cmd   = sse_pkg::SSE_CMD_HOLD;
    count_d    = count_q;
    status     = present ? sse_pkg::SSE_ST_DONE : sse_pkg::SSE_ST_NOT_FOUND;
    unique case (mode)
      sse_pkg::SSE_MODE_INSERT: begin
        if (present) begin
          status = sse_pkg::SSE_ST_DUP;
        end else if (full) begin
          status = sse_pkg::SSE_ST_FULL;
        end else begin
          status = sse_pkg::SSE_ST_DONE;
          if (accept) begin
            ctrl.cmd = sse_pkg::SSE_CMD_INSERT;
            count_d  = count_q + CountW'(1);
          end
        end
      end
      sse_pkg::SSE_MODE_DELETE: begin
        if (present && accept) begin
          ctrl.cmd = sse_pkg::SSE_CMD_DELETE;
          count_d  = count_q - CountW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Element count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q  <= status;
      out_present_q <= present;
      out_count_q   <= 5'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_count_q, out_present_q};
  assign m_axis_tuser  = out_status_q;

endmodule

@@ sv/sse_cell.sv @@
// One storage cell of the sorted row: holds an element and shifts with its neighbours.
module sse_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sse_pkg::sse_ctrl_t ctrl_i,
  input  sse_pkg::sse_link_t left_i,
  input  sse_pkg::sse_link_t right_i,
  output sse_pkg::sse_link_t link_o
);

  logic                             valid_q, valid_d;
  logic signed [sse_pkg::ElemW-1:0] elem_q, elem_d;

  // Compare the held element with the broadcast value.
  always_comb begin
    link_o.valid = valid_q;
    link_o.elem  = elem_q;
    link_o.gt    = valid_q && (elem_q > ctrl_i.value);
    link_o.ge    = valid_q && (elem_q >= ctrl_i.value);
    link_o.eq    = valid_q && (elem_q == ctrl_i.value);
  end

  // Next contents: open a gap on insert, close one on delete.
  always_comb begin
    valid_d = valid_q;
    elem_d  = elem_q;
    unique case (ctrl_i.cmd)
      sse_pkg::SSE_CMD_INSERT: begin
        if (left_i.gt) begin
          valid_d = 1'b1;
          elem_d  = left_i.elem;
        end else if (left_i.valid && (link_o.gt || !valid_q)) begin
          // The left neighbour stays below the value, so the value lands here.
          valid_d = 1'b1;
          elem_d  = ctrl_i.value;
        end
      end
      sse_pkg::SSE_CMD_DELETE: begin
        if (link_o.ge) begin
          valid_d = right_i.valid;
          elem_d  = right_i.elem;
        end
      end
      default: begin
      end
    endcase
  end

  // Occupancy flag is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Element storage needs no reset.
  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

endmodule
